@@ sv/assert_macros.svh @@
// Assertion macros for the RTL cell array. Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ sv/pss_pkg.sv @@
package pss_pkg;

  localparam int CAP_DEFAULT = 16;
  localparam int DW_DEFAULT  = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CNT_O_W = 5;
  localparam int STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // What the cell array does with one command.
  typedef enum logic [1:0] {
    SH_NONE   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2,
    SH_CLEAR  = 2'd3
  } shift_t;

  typedef struct packed {
    shift_t  kind;
    status_t status;
  } op_t;

endpackage

@@ sv/positional_sequence_store.sv @@
// Ordered store of up to CAPACITY data words with entry 0 at the front. A command word is
// taken at every rising edge where start is high; busy is always low, so a new command can
// follow in every cycle. The command is registered, then decoded and applied to the cell
// array in the next cycle, where every cell shifts in parallel for insert and erase; its
// result (removed word, count after the command, status) is registered and presented with
// done high for exactly one cycle, and one result word per cycle is sustained. Results
// come out in command order and the receiver cannot stall them, so it must take every
// word in the cycle that done marks. Commands act on the state left by all earlier
// commands. A pop on an empty store, an insert past the size and an erase at or past
// the size are ignored with status 1; a push or an in-range insert into a full store
// is dropped with status 2; the code with no meaning is ignored with status 1. Stored
// words keep the low DATA_WIDTH bits of value. Entries need no clearing after reset:
// only entries below the count are ever read.
module positional_sequence_store #(
  parameter int CAPACITY   = pss_pkg::CAP_DEFAULT,
  parameter int DATA_WIDTH = pss_pkg::DW_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pss_pkg::CMD_W-1:0]   command,
  input  logic [pss_pkg::POS_W-1:0]   position,
  input  logic [pss_pkg::VAL_W-1:0]   value,
  output logic                        done,
  output logic [pss_pkg::VAL_W-1:0]   removed_value,
  output logic [pss_pkg::CNT_O_W-1:0] count_after,
  output logic [pss_pkg::STAT_W-1:0]  status
);
  import pss_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  // Input register.
  logic             valid_q;
  logic [CMD_W-1:0] cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;

  op_t                   op;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [DATA_WIDTH-1:0] removed;

  // Every command finishes in a single pass, so the block never holds a command off.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= command;
      pos_q <= position;
      val_q <= value;
    end
  end

  // Decode against the current count.
  pss_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .cmd  (cmd_q),
    .pos  (pos_q),
    .count(count),
    .op   (op),
    .idx  (idx)
  );

  // Shift array and count; updates only when a registered command is present.
  pss_cells #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cells (
    .clk       (clk),
    .rst       (rst),
    .en        (valid_q),
    .kind      (op.kind),
    .idx       (idx),
    .word      (DATA_WIDTH'(val_q)),
    .count     (count),
    .count_next(count_next),
    .removed   (removed)
  );

  // Result register: one word per command, strobed by done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_q) begin
      removed_value <= VAL_W'(removed);
      count_after   <= CNT_O_W'(count_next);
      status        <= op.status;
    end
  end

endmodule

@@ sv/pss_ctrl.sv @@
module pss_ctrl #(
  parameter int CAPACITY = pss_pkg::CAP_DEFAULT,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic [pss_pkg::CMD_W-1:0] cmd,
  input  logic [pss_pkg::POS_W-1:0] pos,
  input  logic [CNT_W-1:0]          count,
  output pss_pkg::op_t              op,
  output logic [IDX_W-1:0]          idx
);
  import pss_pkg::*;

  localparam int PCMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic [PCMP_W-1:0] pos_ext;
  logic [PCMP_W-1:0] cnt_ext;
  logic              full;
  logic              empty;

  assign pos_ext = PCMP_W'(pos);
  assign cnt_ext = PCMP_W'(count);
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);

  // Insert checks the position before the capacity, so an out-of-range
  // insert into a full store reports as ignored.
  always_comb begin
    op.kind   = SH_NONE;
    op.status = ST_DONE;
    idx       = '0;
    unique case (cmd)
      CMD_PUSH_BACK: begin
        if (full) op.status = ST_FULL;
        else begin
          op.kind = SH_INSERT;
          idx     = IDX_W'(count);
        end
      end
      CMD_POP_BACK: begin
        if (empty) op.status = ST_IGNORED;
        else begin
          op.kind = SH_REMOVE;
          idx     = IDX_W'(count - 1'b1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) op.status = ST_FULL;
        else op.kind = SH_INSERT;
      end
      CMD_POP_FRONT: begin
        if (empty) op.status = ST_IGNORED;
        else op.kind = SH_REMOVE;
      end
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) op.status = ST_IGNORED;
        else if (full) op.status = ST_FULL;
        else begin
          op.kind = SH_INSERT;
          idx     = IDX_W'(pos);
        end
      end
      CMD_ERASE: begin
        if (pos_ext >= cnt_ext) op.status = ST_IGNORED;
        else begin
          op.kind = SH_REMOVE;
          idx     = IDX_W'(pos);
        end
      end
      CMD_CLEAR: op.kind = SH_CLEAR;
      default:   op.status = ST_IGNORED;
    endcase
  end

endmodule

@@ sv/pss_cells.sv @@
`include "assert_macros.svh"

module pss_cells #(
  parameter int CAPACITY   = pss_pkg::CAP_DEFAULT,
  parameter int DATA_WIDTH = pss_pkg::DW_DEFAULT,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  pss_pkg::shift_t       kind,
  input  logic [IDX_W-1:0]      idx,
  input  logic [DATA_WIDTH-1:0] word,
  output logic [CNT_W-1:0]      count,
  output logic [CNT_W-1:0]      count_next,
  output logic [DATA_WIDTH-1:0] removed
);
  import pss_pkg::*;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];

  assign removed = (kind == SH_REMOVE) ? entries[idx] : '0;

  always_comb begin
    count_next = count;
    if (en) begin
      case (kind)
        SH_INSERT: count_next = count + 1'b1;
        SH_REMOVE: count_next = count - 1'b1;
        SH_CLEAR:  count_next = '0;
        default:   count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Every cell looks only at its neighbors, so insert and erase move all
  // following entries by one place in the same cycle.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] cell_next;
    logic                  at_idx;
    logic                  past_idx;

    assign at_idx   = (IDX_W'(i) == idx);
    assign past_idx = (IDX_W'(i) > idx);

    if (i == 0) begin : g_first
      always_comb begin
        cell_next = entries[i];
        if (kind == SH_INSERT && at_idx) cell_next = word;
        else if (kind == SH_REMOVE && at_idx) cell_next = entries[i+1];
      end
    end else if (i == CAPACITY - 1) begin : g_last
      always_comb begin
        cell_next = entries[i];
        if (kind == SH_INSERT) begin
          if (at_idx) cell_next = word;
          else if (past_idx) cell_next = entries[i-1];
        end
      end
    end else begin : g_mid
      always_comb begin
        cell_next = entries[i];
        if (kind == SH_INSERT) begin
          if (at_idx) cell_next = word;
          else if (past_idx) cell_next = entries[i-1];
        end else if (kind == SH_REMOVE && (at_idx || past_idx)) begin
          cell_next = entries[i+1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) entries[i] <= cell_next;
    end
  end

  `ASSERT_IMPLY(a_no_insert_full, clk, rst, en && kind == SH_INSERT,
                count != CNT_W'(CAPACITY), "insert issued while full")
  `ASSERT_IMPLY(a_no_remove_empty, clk, rst, en && kind == SH_REMOVE,
                count != '0, "remove issued while empty")
  `ASSERT_NEXT(a_insert_lands, clk, rst, en && kind == SH_INSERT,
               entries[$past(idx)] == $past(word), "inserted word not stored at its index")
  `ASSERT_NEXT(a_remove_count, clk, rst, en && kind == SH_REMOVE,
               count == $past(count) - 1'b1, "count did not drop after remove")

endmodule

@@ bench/sequence_store_checker.sv @@
`timescale 1ns / 1ps

// Watches the command and result channels of the sequence store, keeps its own
// copy of the stored words and checks every result word against it in order.
module sequence_store_checker #(
  parameter int CAPACITY   = pss_pkg::CAP_DEFAULT,
  parameter int DATA_WIDTH = pss_pkg::DW_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [pss_pkg::CMD_W-1:0]   command,
  input  logic [pss_pkg::POS_W-1:0]   position,
  input  logic [pss_pkg::VAL_W-1:0]   value,
  input  logic                        done,
  input  logic [pss_pkg::VAL_W-1:0]   removed_value,
  input  logic [pss_pkg::CNT_O_W-1:0] count_after,
  input  logic [pss_pkg::STAT_W-1:0]  status,
  output int                          fail_count,
  output int                          pending,
  output int                          level,
  output int                          checked
);
  import pss_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]   removed;
    logic [CNT_O_W-1:0] count;
    status_t            status;
  } store_result_t;

  logic [DATA_WIDTH-1:0] cells [CAPACITY];
  int                    fill;
  store_result_t         expected_results [$];

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
    fail_count++;
  endtask

  // Shift every word from idx upward by one place and store the new word at idx.
  task automatic open_gap(input int idx, input logic [VAL_W-1:0] word);
    for (int i = fill; i > idx; i--) cells[i] = cells[i-1];
    cells[idx] = word[DATA_WIDTH-1:0];
    fill++;
  endtask

  // Take the word at idx out and close the hole from above.
  task automatic close_gap(input int idx, output logic [VAL_W-1:0] word);
    word = '0;
    word[DATA_WIDTH-1:0] = cells[idx];
    for (int i = idx; i + 1 < fill; i++) cells[i] = cells[i+1];
    fill--;
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val, output store_result_t res);
    logic [VAL_W-1:0] taken;
    status_t          st;
    taken = '0;
    st    = ST_DONE;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (fill >= CAPACITY) st = ST_FULL;
        else open_gap(fill, val);
      end
      CMD_POP_BACK: begin
        if (fill == 0) st = ST_IGNORED;
        else close_gap(fill - 1, taken);
      end
      CMD_PUSH_FRONT: begin
        if (fill >= CAPACITY) st = ST_FULL;
        else open_gap(0, val);
      end
      CMD_POP_FRONT: begin
        if (fill == 0) st = ST_IGNORED;
        else close_gap(0, taken);
      end
      CMD_INSERT: begin
        // The range check wins over the full check.
        if (int'(pos) > fill) st = ST_IGNORED;
        else if (fill >= CAPACITY) st = ST_FULL;
        else open_gap(int'(pos), val);
      end
      CMD_ERASE: begin
        if (int'(pos) >= fill) st = ST_IGNORED;
        else close_gap(int'(pos), taken);
      end
      CMD_CLEAR: fill = 0;
      default: st = ST_IGNORED;
    endcase
    res.removed = taken;
    res.count   = CNT_O_W'(fill);
    res.status  = st;
  endtask

  always @(posedge clk) begin : watch
    store_result_t want;
    store_result_t next;
    if (rst) begin
      fill       = 0;
      fail_count = 0;
      checked    = 0;
      expected_results.delete();
    end else begin
      // Results trail their commands, so check before adding this edge's command.
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no command pending", removed_value, '0);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (removed_value !== want.removed)
            report_mismatch("removed_value", removed_value, want.removed);
          if (count_after !== want.count)
            report_mismatch("count_after", VAL_W'(count_after), VAL_W'(want.count));
          if (status !== want.status)
            report_mismatch("status", VAL_W'(status), VAL_W'(want.status));
        end
      end
      if (start && !busy) begin
        apply_command(command, position, value, next);
        expected_results.insert(expected_results.size(), next);
      end
    end
    pending = expected_results.size();
    level   = fill;
  end

endmodule

@@ bench/positional_sequence_store_test.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the positional sequence store. A checker instance
// beside the block predicts and compares every result word; this module only
// issues command words, paces them, watches for a hang and reports the outcome.
module positional_sequence_store_test;
  import pss_pkg::*;

  localparam int CAPACITY    = CAP_DEFAULT;
  localparam int RANDOM_WORDS = 800;
  // The longest legal quiet stretch is a long sender gap; this limit lies far
  // beyond that and beyond the time a result takes to come back.
  localparam int STALL_LIMIT = 1000;
  // The command code that carries no meaning; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command = '0;
  logic [POS_W-1:0]    position = '0;
  logic [VAL_W-1:0]    value = '0;
  logic                done;
  logic [VAL_W-1:0]    removed_value;
  logic [CNT_O_W-1:0]  count_after;
  logic [STAT_W-1:0]   status;

  int fail_count;
  int pending;
  int level;
  int checked;

  int words_sent = 0;
  int directed_words = 0;
  int words_at_full = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit draining = 1'b0;

  always #1 clk = ~clk;

  positional_sequence_store dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .position      (position),
    .value         (value),
    .done          (done),
    .removed_value (removed_value),
    .count_after   (count_after),
    .status        (status)
  );

  sequence_store_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .position      (position),
    .value         (value),
    .done          (done),
    .removed_value (removed_value),
    .count_after   (count_after),
    .status        (status),
    .fail_count    (fail_count),
    .pending       (pending),
    .level         (level),
    .checked       (checked)
  );

  // The watchdog counts cycles in which neither a command word nor a result
  // word moves. Any such stretch that reaches the limit means the block hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Watchdog: no activity for %0d cycles at %0t ns", STALL_LIMIT, $time);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command word. The caller stands at a falling edge; the task
  // holds the word until a rising edge sees start high with busy low, and
  // returns at the following falling edge so the next word or gap can begin
  // without a second assignment in the same time step.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                       input logic [VAL_W-1:0] val);
    if (level == CAPACITY) words_at_full++;
    start    <= 1'b1;
    command  <= cmd;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Random idle time between words: mostly none or a few cycles, now and then
  // a long gap. Within a no-idle stretch words go back to back.
  task automatic pace();
    int roll;
    int gap;
    roll = $urandom_range(99);
    if (no_idle || roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(3, 1);
    else if (roll < 97) gap = $urandom_range(12, 4);
    else gap = $urandom_range(40, 20);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop sending until every command in flight has produced its result word.
  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Data words lean toward the two extremes now and then.
  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Command choice follows a fill phase and a drain phase so the store keeps
  // travelling between empty and full; a small share of words is pure noise,
  // including the meaningless code.
  function automatic logic [CMD_W-1:0] pick_command();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return CMD_W'($urandom_range(7));
    if (roll < 9) return CMD_CLEAR;
    roll = $urandom_range(99);
    if (!draining) begin
      if (roll < 25) return CMD_PUSH_BACK;
      if (roll < 45) return CMD_PUSH_FRONT;
      if (roll < 70) return CMD_INSERT;
      if (roll < 80) return CMD_POP_BACK;
      if (roll < 90) return CMD_POP_FRONT;
      return CMD_ERASE;
    end
    if (roll < 25) return CMD_POP_BACK;
    if (roll < 50) return CMD_POP_FRONT;
    if (roll < 75) return CMD_ERASE;
    if (roll < 85) return CMD_INSERT;
    if (roll < 93) return CMD_PUSH_BACK;
    return CMD_PUSH_FRONT;
  endfunction

  // Positions are mostly legal for the current fill level, so inserts and
  // erases really shift cells; the rest range from 0 to 16.
  function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
    if ($urandom_range(99) < 15) return POS_W'($urandom_range(16));
    if (cmd == CMD_ERASE && level > 0) return POS_W'($urandom_range(level - 1));
    return POS_W'($urandom_range(level));
  endfunction

  initial begin
    logic [CMD_W-1:0] cmd;

    // Hold the synchronous reset, then release it at a falling edge and let the
    // clock run idle before the first command.
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Directed part. Every pop and erase on the empty store must be ignored,
    // an insert past the size is ignored, and an insert at the size appends.
    issue(CMD_POP_BACK, 5'd0, 32'd0);
    issue(CMD_POP_FRONT, 5'd0, 32'd0);
    issue(CMD_ERASE, 5'd0, 32'd0);
    issue(CMD_INSERT, 5'd1, 32'h1111_1111);
    issue(CMD_UNDEFINED, 5'd16, '1);
    issue(CMD_INSERT, 5'd0, 32'd0);
    issue(CMD_PUSH_FRONT, 5'd0, '1);
    pace();
    issue(CMD_PUSH_BACK, 5'd0, 32'hA5A5_5A5A);
    issue(CMD_INSERT, 5'd1, 32'h8000_0001);
    // Four words stored: an erase at the size is out of range, one in the
    // middle closes the gap.
    issue(CMD_ERASE, 5'd4, 32'd0);
    issue(CMD_ERASE, 5'd1, 32'd0);
    issue(CMD_POP_BACK, 5'd0, 32'd0);
    issue(CMD_POP_FRONT, 5'd0, 32'd0);
    issue(CMD_CLEAR, 5'd0, 32'd0);
    issue(CMD_CLEAR, 5'd0, 32'd0);
    hold_until_drained();

    // Fill to capacity, then try every way of adding a word to a full store.
    // An insert at position sixteen is in range when full and must report
    // the full status; once one word is gone, the same insert is past the
    // size and must be ignored instead.
    repeat (CAPACITY) issue(CMD_PUSH_BACK, 5'd0, pick_value());
    issue(CMD_PUSH_BACK, 5'd0, 32'h0BAD_0BAD);
    issue(CMD_PUSH_FRONT, 5'd0, 32'h0BAD_0BAD);
    issue(CMD_INSERT, 5'd16, 32'h0BAD_0BAD);
    issue(CMD_INSERT, 5'd5, 32'h0BAD_0BAD);
    issue(CMD_ERASE, 5'd16, 32'd0);
    issue(CMD_ERASE, 5'd15, 32'd0);
    issue(CMD_INSERT, 5'd16, 32'h0BAD_0BAD);
    directed_words = words_sent;
    hold_until_drained();

    // Random part. Every 200 words the last 50 go without any idle time, and
    // once in the middle the sender waits for the store to answer everything.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_idle = (n % 200) >= 150;
      if (n == RANDOM_WORDS / 2) hold_until_drained();
      if (level == CAPACITY && $urandom_range(3) == 0) draining = 1'b1;
      if (level == 0 && $urandom_range(3) == 0) draining = 1'b0;
      cmd = pick_command();
      issue(cmd, pick_position(cmd), pick_value());
      pace();
    end

    // Let the last results come back, then watch a few more cycles for any
    // stray result word.
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Run covered %0d command words (%0d directed), %0d of them sent to a full store.",
             words_sent, directed_words, words_at_full);
    $display("Results checked: %0d, mismatches: %0d.", checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/pss_pkg.sv
sv/pss_ctrl.sv
sv/pss_cells.sv
sv/positional_sequence_store.sv
bench/sequence_store_checker.sv
bench/positional_sequence_store_test.sv
